[sv/llt_pkg.sv]
// Package: shared constants, types and helper functions of the lease lock table.
`default_nettype none
package llt_pkg;

  localparam int TOTAL_BUSES     = 4;
  localparam int ENTRIES_PER_BUS = 256;
  localparam int SESSION_BITS    = 16;

  localparam int TABLE_SIZE = TOTAL_BUSES * ENTRIES_PER_BUS;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int ADDR_W     = $clog2(ENTRIES_PER_BUS);
  localparam int BUS_W      = (TOTAL_BUSES > 1) ? $clog2(TOTAL_BUSES) : 1;
  localparam int REL_W      = $clog2(TABLE_SIZE + 1);

  // Port field widths
  localparam int REQ_W      = 3;
  localparam int IN_BUS_W   = 2;
  localparam int IN_ADDR_W  = 8;
  localparam int IN_SESS_W  = 16;
  localparam int LEASE_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int HOLDER_W   = 16;
  localparam int RELEASED_W = 11;

  // Configuration port
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 8;
  localparam int LIMIT_W        = 2;
  localparam int COUNT_W        = 8;
  localparam int NUM_COUNT_REGS = 4;
  localparam int COUNT_SEL_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BUS_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_BUS0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_BUS1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_BUS2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_BUS3 = 3'd4;

  // Command queue
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    OP_ACTIVATE  = 3'd0,
    OP_TERMINATE = 3'd1,
    OP_LOCK      = 3'd2,
    OP_UNLOCK    = 3'd3,
    OP_QUERY     = 3'd4,
    OP_TICK      = 3'd5,
    OP_SESS_END  = 3'd6,
    OP_BAD       = 3'd7
  } llt_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_WRONG  = 2'd1,
    ST_LOCKED = 2'd2,
    ST_NODATA = 2'd3
  } llt_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_DRAIN
  } llt_state_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]                     bus_limit;
    logic [NUM_COUNT_REGS-1:0][COUNT_W-1:0] count;
  } llt_cfg_t;

  typedef struct packed {
    logic                    active;
    logic [SESSION_BITS-1:0] holder;
    logic [LEASE_W-1:0]      lease;
  } llt_entry_t;

  typedef struct packed {
    llt_op_t                 op;
    logic                    addr_ok;
    logic [SLOT_W-1:0]       slot;
    logic [SESSION_BITS-1:0] session;
    logic [LEASE_W-1:0]      lease;
  } llt_cmd_t;

  // Usable entry count of a bus; zero beyond the bus limit
  function automatic logic [COUNT_W-1:0] count_of(llt_cfg_t cfg, int b);
    logic [COUNT_W-1:0] c;
    c = '0;
    if (b <= int'(cfg.bus_limit) && b < TOTAL_BUSES && b < NUM_COUNT_REGS) begin
      c = cfg.count[b[COUNT_SEL_W-1:0]];
      if (int'(c) > ENTRIES_PER_BUS - 1) begin
        c = COUNT_W'(ENTRIES_PER_BUS - 1);
      end
    end
    return c;
  endfunction

  function automatic logic addr_ok(llt_cfg_t cfg, int b, int a);
    return (a >= 1) && (a <= int'(count_of(cfg, b)));
  endfunction

endpackage
`default_nettype wire

[sv/llt_req_if.sv]
// Interface: request channel carrying one table request per transaction.
`default_nettype none
interface llt_req_if;
  logic                            valid;
  logic                            ready;
  logic [llt_pkg::REQ_W-1:0]       req_type;
  logic [llt_pkg::IN_BUS_W-1:0]    bus;
  logic [llt_pkg::IN_ADDR_W-1:0]   addr;
  logic [llt_pkg::IN_SESS_W-1:0]   session;
  logic [llt_pkg::LEASE_W-1:0]     lease;

  modport source (output valid, req_type, bus, addr, session, lease, input ready);
  modport sink   (input valid, req_type, bus, addr, session, lease, output ready);
endinterface
`default_nettype wire

[sv/llt_rsp_if.sv]
// Interface: response channel carrying one result per transaction.
`default_nettype none
interface llt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [llt_pkg::STATUS_W-1:0]     status;
  logic [llt_pkg::HOLDER_W-1:0]     holder;
  logic [llt_pkg::RELEASED_W-1:0]   released;

  modport source (output valid, status, holder, released, input ready);
  modport sink   (input valid, status, holder, released, output ready);
endinterface
`default_nettype wire

[sv/llt_front.sv]
// Front end: accepts requests, decodes the operation and resolves the table slot.
`default_nettype none
module llt_front (
  llt_req_if.sink             req,
  input  llt_pkg::llt_cfg_t   cfg,
  input  logic                clearing,
  input  logic                full,
  output logic                push,
  output llt_pkg::llt_cmd_t   cmd
);

  logic ok;

  assign req.ready = !clearing && !full;
  assign push      = req.valid && req.ready;
  assign ok        = llt_pkg::addr_ok(cfg, int'(req.bus), int'(req.addr));

  always_comb begin
    cmd.op      = llt_pkg::llt_op_t'(req.req_type);
    cmd.addr_ok = ok;
    cmd.slot    = ok ? llt_pkg::SLOT_W'(int'(req.bus) * llt_pkg::ENTRIES_PER_BUS
                                        + int'(req.addr))
                     : '0;
    cmd.session = llt_pkg::SESSION_BITS'(req.session);
    cmd.lease   = req.lease;
  end

endmodule
`default_nettype wire

[sv/llt_fifo.sv]
// Command queue between the front end and the table engine.
`default_nettype none
module llt_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  llt_pkg::llt_cmd_t  push_data,
  output logic               full,
  input  logic               pop,
  output llt_pkg::llt_cmd_t  head,
  output logic               nempty
);

  llt_pkg::llt_cmd_t              slots [llt_pkg::FIFO_DEPTH];
  logic [llt_pkg::FIFO_AW-1:0]    wptr;
  logic [llt_pkg::FIFO_AW-1:0]    rptr;
  logic [llt_pkg::FIFO_CW-1:0]    fill;

  assign full   = (fill == llt_pkg::FIFO_CW'(llt_pkg::FIFO_DEPTH));
  assign nempty = (fill != '0);
  assign head   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == llt_pkg::FIFO_AW'(llt_pkg::FIFO_DEPTH - 1)) ? '0
                                                                    : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == llt_pkg::FIFO_AW'(llt_pkg::FIFO_DEPTH - 1)) ? '0
                                                                    : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/llt_back.sv]
// Table engine: entry memory, single-entry updates, sweeps and result register.
`default_nettype none
module llt_back (
  input  logic               clk,
  input  logic               rst,
  input  llt_pkg::llt_cfg_t  cfg,
  input  logic               nempty,
  input  llt_pkg::llt_cmd_t  head,
  output logic               pop,
  output logic               clearing,
  llt_rsp_if.source          rsp
);

  localparam logic [llt_pkg::SLOT_W-1:0] LAST_SLOT = llt_pkg::SLOT_W'(llt_pkg::TABLE_SIZE - 1);
  localparam logic [llt_pkg::ADDR_W-1:0] LAST_ADDR =
    llt_pkg::ADDR_W'(llt_pkg::ENTRIES_PER_BUS - 1);

  llt_pkg::llt_entry_t mem [llt_pkg::TABLE_SIZE];
  llt_pkg::llt_entry_t rd_data;
  llt_pkg::llt_entry_t mem_wdata;
  logic                          mem_we;
  logic [llt_pkg::SLOT_W-1:0]    mem_waddr;
  logic [llt_pkg::SLOT_W-1:0]    mem_raddr;

  llt_pkg::llt_state_t state, state_next;
  llt_pkg::llt_cmd_t   cur;

  logic [llt_pkg::SLOT_W-1:0] sc_slot;
  logic [llt_pkg::BUS_W-1:0]  sc_bus;
  logic [llt_pkg::ADDR_W-1:0] sc_addr;
  logic                       p_valid;
  logic [llt_pkg::SLOT_W-1:0] p_slot;
  logic                       p_inr;
  logic [llt_pkg::REL_W-1:0]  released_cnt;

  logic                      out_valid;
  llt_pkg::llt_status_t      out_status;
  logic [llt_pkg::HOLDER_W-1:0]   out_holder;
  logic [llt_pkg::RELEASED_W-1:0] out_released;

  logic                      finish;
  llt_pkg::llt_status_t      res_status;
  logic [llt_pkg::HOLDER_W-1:0]   res_holder;
  logic [llt_pkg::RELEASED_W-1:0] res_released;
  llt_pkg::llt_entry_t       scan_wdata;
  logic                      scan_hit;
  logic                      owner_ok;
  logic                      active;

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.holder   = out_holder;
  assign rsp.released = out_released;
  assign clearing     = (state == llt_pkg::S_CLEAR);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llt_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sweep step on the entry read last cycle
  always_comb begin
    scan_wdata = rd_data;
    scan_hit   = 1'b0;
    if (p_inr) begin
      if (cur.op == llt_pkg::OP_TICK) begin
        if (rd_data.lease != '0) begin
          scan_wdata.lease = rd_data.lease - 1'b1;
          if (rd_data.lease == llt_pkg::LEASE_W'(1) && rd_data.active) begin
            scan_wdata.holder = '0;
            scan_hit          = 1'b1;
          end
        end
      end else if (cur.session != '0 && rd_data.active
                   && rd_data.holder == cur.session) begin
        scan_wdata.holder = '0;
        scan_hit          = 1'b1;
      end
    end
  end

  assign active   = cur.addr_ok && rd_data.active;
  assign owner_ok = (rd_data.holder == cur.session) || (rd_data.holder == '0);

  always_comb begin
    state_next   = state;
    pop          = 1'b0;
    finish       = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cur.slot;
    mem_wdata    = rd_data;
    mem_raddr    = head.slot;
    res_status   = llt_pkg::ST_OK;
    res_holder   = '0;
    res_released = '0;
    case (state)
      llt_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sc_slot;
        mem_wdata = '0;
        if (sc_slot == LAST_SLOT) begin
          state_next = llt_pkg::S_IDLE;
        end
      end
      llt_pkg::S_IDLE: begin
        if (nempty && (!out_valid || rsp.ready)) begin
          pop = 1'b1;
          if (head.op == llt_pkg::OP_TICK || head.op == llt_pkg::OP_SESS_END) begin
            state_next = llt_pkg::S_SCAN;
          end else begin
            state_next = llt_pkg::S_LOOK;
          end
        end
      end
      llt_pkg::S_LOOK: begin
        finish     = 1'b1;
        state_next = llt_pkg::S_IDLE;
        case (cur.op)
          llt_pkg::OP_ACTIVATE: begin
            if (!cur.addr_ok) begin
              res_status = llt_pkg::ST_WRONG;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = '0;
              mem_wdata.active = 1'b1;
            end
          end
          llt_pkg::OP_TERMINATE: begin
            if (!active) begin
              res_status = llt_pkg::ST_NODATA;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = '0;
            end
          end
          llt_pkg::OP_LOCK: begin
            if (!active) begin
              res_status = llt_pkg::ST_WRONG;
            end else if (owner_ok) begin
              mem_we           = 1'b1;
              mem_wdata.holder = cur.session;
              mem_wdata.lease  = cur.lease;
            end else begin
              res_status = llt_pkg::ST_LOCKED;
            end
          end
          llt_pkg::OP_UNLOCK: begin
            if (!active) begin
              res_status = llt_pkg::ST_WRONG;
            end else if (owner_ok) begin
              mem_we           = 1'b1;
              mem_wdata.holder = '0;
            end else begin
              res_status = llt_pkg::ST_LOCKED;
            end
          end
          llt_pkg::OP_QUERY: begin
            if (!active) begin
              res_status = llt_pkg::ST_WRONG;
            end else begin
              res_holder = llt_pkg::HOLDER_W'(rd_data.holder);
            end
          end
          default: begin
            res_status = llt_pkg::ST_WRONG;
          end
        endcase
      end
      llt_pkg::S_SCAN: begin
        mem_raddr = sc_slot;
        mem_we    = p_valid;
        mem_waddr = p_slot;
        mem_wdata = scan_wdata;
        if (sc_slot == LAST_SLOT) begin
          state_next = llt_pkg::S_DRAIN;
        end
      end
      llt_pkg::S_DRAIN: begin
        mem_we       = p_valid;
        mem_waddr    = p_slot;
        mem_wdata    = scan_wdata;
        finish       = 1'b1;
        res_released = llt_pkg::RELEASED_W'(released_cnt + llt_pkg::REL_W'(scan_hit));
        state_next   = llt_pkg::S_IDLE;
      end
      default: begin
        state_next = llt_pkg::S_IDLE;
      end
    endcase
  end

  // Command, sweep counters and sweep pipeline
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == llt_pkg::S_SCAN) begin
      p_slot <= sc_slot;
      p_inr  <= llt_pkg::addr_ok(cfg, int'(sc_bus), int'(sc_addr));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_slot      <= '0;
      sc_bus       <= '0;
      sc_addr      <= '0;
      p_valid      <= 1'b0;
      released_cnt <= '0;
    end else begin
      case (state)
        llt_pkg::S_CLEAR: begin
          sc_slot <= (sc_slot == LAST_SLOT) ? '0 : sc_slot + 1'b1;
        end
        llt_pkg::S_IDLE: begin
          sc_slot      <= '0;
          sc_bus       <= '0;
          sc_addr      <= '0;
          p_valid      <= 1'b0;
          released_cnt <= '0;
        end
        llt_pkg::S_SCAN: begin
          p_valid <= 1'b1;
          if (p_valid) begin
            released_cnt <= released_cnt + llt_pkg::REL_W'(scan_hit);
          end
          if (sc_slot != LAST_SLOT) begin
            sc_slot <= sc_slot + 1'b1;
          end
          if (sc_addr == LAST_ADDR) begin
            sc_addr <= '0;
            sc_bus  <= sc_bus + 1'b1;
          end else begin
            sc_addr <= sc_addr + 1'b1;
          end
        end
        llt_pkg::S_DRAIN: begin
          p_valid <= 1'b0;
        end
        default: begin
          p_valid <= 1'b0;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status   <= res_status;
      out_holder   <= res_holder;
      out_released <= res_released;
    end
  end

endmodule
`default_nettype wire

[sv/lease_lock_table.sv]
// Top level: configuration registers, request front end, command queue and table engine.
`default_nettype none
// Lease lock table. Requests arrive on req and each yields exactly one
// transaction on rsp, in request order. Lock, unlock, query, activate and
// terminate access one entry of the table memory, passing through the
// command queue, the entry read register and the result register; the
// engine takes no new command until the last has finished and the rsp
// register is empty or being read. Tick and session end sweep every slot of
// the table through one read and one write memory port, one slot per cycle,
// and give their result after the whole sweep (1024 slots with four buses of
// 256 entries). After reset the engine zeroes the table, and req.ready stays
// low until that pass is done. Configuration writes take effect at once, so
// make them only while no request is queued or executing.
// The two-entry command queue lets the front end take a new request while the
// engine is still busy and while a finished result waits in the rsp register.
module lease_lock_table (
  input  logic                               clk,
  input  logic                               rst,
  llt_req_if.sink                            req,
  llt_rsp_if.source                          rsp,
  input  logic                               cfg_we,
  input  logic [llt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [llt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  llt_pkg::llt_cfg_t cfg;
  llt_pkg::llt_cmd_t push_cmd;
  llt_pkg::llt_cmd_t head;
  logic              push;
  logic              full;
  logic              pop;
  logic              nempty;
  logic              clearing;

  // Hold the configuration registers; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        llt_pkg::REG_BUS_LIMIT:  cfg.bus_limit <= llt_pkg::LIMIT_W'(cfg_data);
        llt_pkg::REG_COUNT_BUS0: cfg.count[0]  <= llt_pkg::COUNT_W'(cfg_data);
        llt_pkg::REG_COUNT_BUS1: cfg.count[1]  <= llt_pkg::COUNT_W'(cfg_data);
        llt_pkg::REG_COUNT_BUS2: cfg.count[2]  <= llt_pkg::COUNT_W'(cfg_data);
        llt_pkg::REG_COUNT_BUS3: cfg.count[3]  <= llt_pkg::COUNT_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Decode and address-check each request transaction
  llt_front u_front (
    .req      (req),
    .cfg      (cfg),
    .clearing (clearing),
    .full     (full),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Decouple acceptance from execution
  llt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .nempty    (nempty)
  );

  // Execute commands against the entry memory and register the result
  llt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .nempty   (nempty),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

endmodule
`default_nettype wire
